// ----- rtl/cab_pkg.sv -----
`timescale 1ns / 1ps

package cab_pkg;

    // Default build sizes
    localparam int MAX_CELLS_DEF = 96;
    localparam int WINDOW_DEF    = 5;

    // Fixed field widths
    localparam int VOLT_W = 16;
    localparam int CELLN_W = 7;
    localparam int LEN_W = 8;     // holds any frame length up to 128

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_BAL_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_CELLS  = 2'd1;

    localparam logic [VOLT_W-1:0]  BAL_THRESHOLD_RST = 16'd500;
    localparam logic [CELLN_W-1:0] ACTIVE_CELLS_RST  = 7'd90;

endpackage

// ----- rtl/cab_in_if.sv -----
`timescale 1ns / 1ps

interface cab_in_if;
    logic                         valid;
    logic                         ready;
    logic [cab_pkg::VOLT_W-1:0]   raw_voltage;
    logic                         charging;

    modport source (output valid, output raw_voltage, output charging, input ready);
    modport sink   (input valid, input raw_voltage, input charging, output ready);
endinterface

// ----- rtl/cab_out_if.sv -----
`timescale 1ns / 1ps

interface cab_out_if;
    logic                          valid;
    logic                          ready;
    logic [cab_pkg::VOLT_W-1:0]    filtered_voltage;
    logic [cab_pkg::CELLN_W-1:0]   cell_number;
    logic                          frame_done;
    logic [cab_pkg::VOLT_W-1:0]    max_voltage;
    logic [cab_pkg::VOLT_W-1:0]    min_voltage;
    logic                          balance_needed;
    logic [cab_pkg::CELLN_W-1:0]   balance_cell;

    modport source (
        output valid, output filtered_voltage, output cell_number, output frame_done,
        output max_voltage, output min_voltage, output balance_needed,
        output balance_cell, input ready
    );
    modport sink (
        input valid, input filtered_voltage, input cell_number, input frame_done,
        input max_voltage, input min_voltage, input balance_needed,
        input balance_cell, output ready
    );
endinterface

// ----- rtl/cab_ram.sv -----
`timescale 1ns / 1ps

module cab_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 768,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/cell_average_and_balance_check.sv -----
`timescale 1ns / 1ps

// Cell voltage averaging with frame max/min tracking and balance request.
// i_in carries one raw cell voltage per beat, cells in frame order; o_out
// returns one beat per input: the cell's mean over its last WINDOW frames
// (fewer while the history fills), its position, and on the last cell of
// the frame the max, min and the balance request with the 1-based max cell.
// The config port (i_cfg_we/i_cfg_idx/i_cfg_data) sets the balance threshold
// (index 0) and the frame length (index 1); write it only while idle.
// Each beat stores the sample, then reads back count history words, count =
// frames averaged (1 to WINDOW), through the single RAM read port, with a read
// state and an accumulate state per word; the bit-serial divider then forms
// SUM_W quotient bits (19 with the default sizes); max/min are updated and
// the output register is loaded.
// i_in.ready is high only while the sequencer is idle. A finished result sits
// in the output register; if the receiver stalls, the next beat is still
// taken and processed, and the sequencer then holds until the register frees.
// Reset (synchronous, active low) restarts at cell 0 with an empty history
// and restores the default threshold and frame length; no clearing pass.
module cell_average_and_balance_check #(
    parameter int MAX_CELLS = cab_pkg::MAX_CELLS_DEF,
    parameter int WINDOW    = cab_pkg::WINDOW_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [cab_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [cab_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    cab_in_if.sink                          i_in,
    cab_out_if.source                       o_out
);

    localparam int VW     = cab_pkg::VOLT_W;
    localparam int NW     = cab_pkg::CELLN_W;
    localparam int LW     = cab_pkg::LEN_W;
    localparam int CELL_W = $clog2(MAX_CELLS);
    localparam int SLOT_W = $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SUM_W  = VW + CNT_W;
    localparam int DC_W   = $clog2(SUM_W);
    localparam int AW     = CELL_W + SLOT_W;
    localparam int DEPTH  = MAX_CELLS * (2 ** SLOT_W);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_ACC  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_UPD  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0]        r_state;
    logic [VW-1:0]     r_thr;
    logic [NW-1:0]     r_act;
    logic [CELL_W-1:0] r_cell;
    logic [SLOT_W-1:0] r_slot;
    logic [CNT_W-1:0]  r_filled;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_k;
    logic [SUM_W-1:0]  r_sum;
    logic [CNT_W-1:0]  r_rem;
    logic [DC_W-1:0]   r_dcnt;
    logic              r_chg;
    logic [VW-1:0]     r_max;
    logic [VW-1:0]     r_min;
    logic [CELL_W-1:0] r_max_pos;

    logic              r_o_valid;
    logic [VW-1:0]     r_o_filt;
    logic [NW-1:0]     r_o_cell;
    logic              r_o_done;
    logic [VW-1:0]     r_o_max;
    logic [VW-1:0]     r_o_min;
    logic              r_o_bal;
    logic [NW-1:0]     r_o_bal_cell;

    logic              accept;
    logic              out_free;
    logic [AW-1:0]     ram_waddr;
    logic [AW-1:0]     ram_raddr;
    logic [VW-1:0]     ram_rdata;
    logic [CNT_W:0]    div_trial;
    logic              div_ge;
    logic [VW-1:0]     mean;
    logic [LW-1:0]     frame_len;
    logic              last;
    logic              bal;
    logic [SLOT_W-1:0] n_slot;

    assign accept    = i_in.valid && (r_state == ST_IDLE);
    assign out_free  = !r_o_valid || o_out.ready;
    assign ram_waddr = {r_cell, r_slot};
    assign ram_raddr = {r_cell, r_k[SLOT_W-1:0]};

    cab_ram #(
        .WIDTH (VW),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (ram_waddr),
        .i_wdata (i_in.raw_voltage),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // restoring divide, one quotient bit per cycle shifted into r_sum
    assign div_trial = {r_rem, r_sum[SUM_W-1]};
    assign div_ge    = div_trial >= {1'b0, r_count};
    assign mean      = r_sum[VW-1:0];

    always_comb begin
        if (r_act == '0) begin
            frame_len = LW'(1);
        end else if ({1'b0, r_act} > LW'(MAX_CELLS)) begin
            frame_len = LW'(MAX_CELLS);
        end else begin
            frame_len = {1'b0, r_act};
        end
    end

    assign last   = (LW'(r_cell) + LW'(1)) >= frame_len;
    assign bal    = r_chg && ((r_max - r_min) >= r_thr);
    assign n_slot = (r_slot == SLOT_W'(WINDOW - 1)) ? '0 : r_slot + SLOT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= cab_pkg::BAL_THRESHOLD_RST;
            r_act <= cab_pkg::ACTIVE_CELLS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                cab_pkg::REG_BAL_THRESHOLD: r_thr <= i_cfg_data;
                cab_pkg::REG_ACTIVE_CELLS:  r_act <= i_cfg_data[NW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cell    <= '0;
            r_slot    <= '0;
            r_filled  <= '0;
            r_max     <= '0;
            r_min     <= '0;
            r_max_pos <= '0;
            r_o_valid <= 1'b0;
        end else begin
            // a new result loading this cycle takes over the valid flag
            if (o_out.ready && !((r_state == ST_OUT) && out_free)) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_chg   <= i_in.charging;
                        r_count <= (r_filled == CNT_W'(WINDOW)) ? r_filled
                                                                : r_filled + CNT_W'(1);
                        r_k     <= '0;
                        r_sum   <= '0;
                        r_state <= ST_READ;
                    end
                end
                ST_READ: begin
                    r_state <= ST_ACC;
                end
                ST_ACC: begin
                    r_sum <= r_sum + SUM_W'(ram_rdata);
                    if (r_k == r_count - CNT_W'(1)) begin
                        r_rem   <= '0;
                        r_dcnt  <= DC_W'(SUM_W - 1);
                        r_state <= ST_DIV;
                    end else begin
                        r_k     <= r_k + CNT_W'(1);
                        r_state <= ST_READ;
                    end
                end
                ST_DIV: begin
                    r_rem <= div_ge ? CNT_W'(div_trial - {1'b0, r_count})
                                    : div_trial[CNT_W-1:0];
                    r_sum <= {r_sum[SUM_W-2:0], div_ge};
                    if (r_dcnt == '0) begin
                        r_state <= ST_UPD;
                    end else begin
                        r_dcnt <= r_dcnt - DC_W'(1);
                    end
                end
                ST_UPD: begin
                    // first cell seeds the frame; strict compares keep the earliest tie
                    if (r_cell == '0) begin
                        r_max     <= mean;
                        r_min     <= mean;
                        r_max_pos <= '0;
                    end else begin
                        if (mean > r_max) begin
                            r_max     <= mean;
                            r_max_pos <= r_cell;
                        end
                        if (mean < r_min) begin
                            r_min <= mean;
                        end
                    end
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_o_valid    <= 1'b1;
                        r_o_filt     <= mean;
                        r_o_cell     <= NW'(r_cell);
                        r_o_done     <= last;
                        r_o_max      <= last ? r_max : '0;
                        r_o_min      <= last ? r_min : '0;
                        r_o_bal      <= last && bal;
                        r_o_bal_cell <= (last && bal) ? NW'(LW'(r_max_pos) + LW'(1)) : '0;
                        if (last) begin
                            r_cell <= '0;
                            r_slot <= n_slot;
                            if (r_filled != CNT_W'(WINDOW)) begin
                                r_filled <= r_filled + CNT_W'(1);
                            end
                        end else begin
                            r_cell <= r_cell + CELL_W'(1);
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign i_in.ready             = (r_state == ST_IDLE);
    assign o_out.valid            = r_o_valid;
    assign o_out.filtered_voltage = r_o_filt;
    assign o_out.cell_number      = r_o_cell;
    assign o_out.frame_done       = r_o_done;
    assign o_out.max_voltage      = r_o_max;
    assign o_out.min_voltage      = r_o_min;
    assign o_out.balance_needed   = r_o_bal;
    assign o_out.balance_cell     = r_o_bal_cell;

endmodule
